// File: rtl/positional_array_list_unit_macros.svh
// Assertion macros shared by the list unit RTL.
// Bodies assume a clock named clock and a synchronous reset named reset.
`ifndef POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH

// same-cycle implication
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pal_pkg.sv
// Shared types and codes for the positional array list unit.
// No dependencies; every RTL module and interface imports this package.
package pal_pkg;

   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_GET    = 3'd0,
      OP_LOCATE = 3'd1,
      OP_INSERT = 3'd2,
      OP_DELETE = 3'd3,
      OP_CLEAR  = 3'd4
   } pal_op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } pal_status_type;

   // broadcast shift command to the cell row
   typedef struct packed {
      logic ins;
      logic del;
   } pal_cmd_type;

   // control flags of the probe that walks the cell row
   typedef struct packed {
      logic valid;
      logic locate;
      logic hit;
   } pal_probe_type;

endpackage

// File: rtl/pal_ifs.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on pal_pkg for the payload widths.
interface pal_req_if;
   import pal_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [POS_W-1:0]  position;
   logic [DATA_W-1:0] value;
   modport source (output valid, operation, position, value, input ready);
   modport sink   (input valid, operation, position, value, output ready);
endinterface

interface pal_rsp_if;
   import pal_pkg::*;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [DATA_W-1:0] read_value;
   logic [POS_W-1:0]  found_position;
   logic [POS_W-1:0]  list_length;
   logic              is_empty;
   modport source (output valid, status, read_value, found_position, list_length, is_empty,
                   input ready);
   modport sink   (input valid, status, read_value, found_position, list_length, is_empty,
                   output ready);
endinterface

// File: rtl/pal_cell.sv
// One list cell: holds a single entry, shifts with its neighbors, and
// passes the search/read probe on to the next cell. Depends on pal_pkg.
module pal_cell #(
   parameter int ELEM_WIDTH = 32,
   parameter int PW         = 7,
   parameter int POSITION   = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pal_pkg::pal_cmd_type   cmd,
   input  logic [PW-1:0]          cmd_pos,
   input  logic [ELEM_WIDTH-1:0]  cmd_word,
   input  logic [ELEM_WIDTH-1:0]  lower_word,
   input  logic [ELEM_WIDTH-1:0]  upper_word,
   output logic [ELEM_WIDTH-1:0]  entry_word,
   input  logic [PW-1:0]          list_count,
   input  pal_pkg::pal_probe_type probe_in,
   input  logic [ELEM_WIDTH-1:0]  probe_word_in,
   input  logic [PW-1:0]          probe_target_in,
   input  logic [PW-1:0]          probe_pos_in,
   output pal_pkg::pal_probe_type probe_out,
   output logic [ELEM_WIDTH-1:0]  probe_word_out,
   output logic [PW-1:0]          probe_target_out,
   output logic [PW-1:0]          probe_pos_out
);
   import pal_pkg::*;

   localparam logic [PW-1:0] MY_POS = PW'(POSITION);

   logic [ELEM_WIDTH-1:0] entry_ff, entry_in;
   pal_probe_type         probe_ff, probe_in_nx;
   logic [ELEM_WIDTH-1:0] word_ff, word_in;
   logic [PW-1:0]         target_ff, target_in;
   logic [PW-1:0]         fpos_ff, fpos_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (cmd_pos == MY_POS) begin
            entry_in = cmd_word;
         end else if (cmd_pos < MY_POS) begin
            entry_in = lower_word;
         end
      end else if (cmd.del && (cmd_pos <= MY_POS)) begin
         entry_in = upper_word;
      end
   end

   always_comb begin
      probe_in_nx = probe_in;
      word_in     = probe_word_in;
      target_in   = probe_target_in;
      fpos_in     = probe_pos_in;
      if (probe_in.valid && !probe_in.hit) begin
         if (probe_in.locate) begin
            // only cells inside the current length may match
            if ((MY_POS <= list_count) && (entry_ff == probe_word_in)) begin
               probe_in_nx.hit = 1'b1;
               fpos_in         = MY_POS;
            end
         end else if (probe_target_in == MY_POS) begin
            probe_in_nx.hit = 1'b1;
            word_in         = entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      word_ff   <= word_in;
      target_ff <= target_in;
      fpos_ff   <= fpos_in;
   end

   assign entry_word       = entry_ff;
   assign probe_out        = probe_ff;
   assign probe_word_out   = word_ff;
   assign probe_target_out = target_ff;
   assign probe_pos_out    = fpos_ff;

endmodule

// File: rtl/pal_ctrl.sv
// Sequencer of the list unit: decodes request beats, keeps the length,
// drives shift commands and probes into the cell row, holds the response.
// Depends on pal_pkg, pal_ifs and the assertion macro header.
`include "positional_array_list_unit_macros.svh"

module pal_ctrl #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32,
   parameter int PW         = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   pal_req_if.sink                req_chan,
   pal_rsp_if.source              rsp_chan,
   output pal_pkg::pal_cmd_type   cmd,
   output logic [PW-1:0]          cmd_pos,
   output logic [ELEM_WIDTH-1:0]  cmd_word,
   output logic [PW-1:0]          list_count,
   output pal_pkg::pal_probe_type launch,
   output logic [ELEM_WIDTH-1:0]  launch_word,
   output logic [PW-1:0]          launch_target,
   input  pal_pkg::pal_probe_type probe_ret,
   input  logic [ELEM_WIDTH-1:0]  probe_ret_word,
   input  logic [PW-1:0]          probe_ret_pos
);
   import pal_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } pal_state_type;

   pal_state_type  state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           del_ff, del_in;
   logic [PW-1:0]  pos_ff, pos_in;

   logic              rsp_valid_ff, rsp_valid_in;
   pal_status_type    status_ff, status_in;
   logic [DATA_W-1:0] rdval_ff, rdval_in;
   logic [POS_W-1:0]  fpos_ff, fpos_in;
   logic [POS_W-1:0]  len_ff, len_in;
   logic              empty_ff, empty_in;

   logic [ELEM_WIDTH-1:0] elem_value;
   logic [DATA_W-1:0]     ret_value;
   logic [PW-1:0]         pos_w, cnt_w;
   logic                  accept, range_rd, range_ins, full;
   logic                  resp_now;
   pal_status_type        resp_status;

   generate
      if (ELEM_WIDTH <= DATA_W) begin : g_val_narrow
         assign elem_value = req_chan.value[ELEM_WIDTH-1:0];
      end else begin : g_val_wide
         assign elem_value = {{(ELEM_WIDTH-DATA_W){1'b0}}, req_chan.value};
      end
      if (ELEM_WIDTH < DATA_W) begin : g_ret_narrow
         assign ret_value = {{(DATA_W-ELEM_WIDTH){1'b0}}, probe_ret_word};
      end else begin : g_ret_wide
         assign ret_value = probe_ret_word[DATA_W-1:0];
      end
   endgenerate

   assign pos_w     = PW'(req_chan.position);
   assign cnt_w     = PW'(count_ff);
   assign range_rd  = (pos_w != '0) && (pos_w <= cnt_w);
   assign range_ins = (pos_w != '0) && ((pos_w - PW'(1)) <= cnt_w);
   assign full      = (cnt_w == PW'(CAPACITY));

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      del_in        = del_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      status_in     = status_ff;
      rdval_in      = rdval_ff;
      fpos_in       = fpos_ff;
      len_in        = len_ff;
      empty_in      = empty_ff;
      cmd           = '0;
      cmd_pos       = pos_w;
      cmd_word      = elem_value;
      launch        = '0;
      launch_word   = elem_value;
      launch_target = pos_w;
      resp_now      = 1'b0;
      resp_status   = ST_OK;

      if (accept) begin
         case (req_chan.operation)
            OP_GET: begin
               if (range_rd) begin
                  launch.valid = 1'b1;
                  del_in       = 1'b0;
                  state_in     = S_SCAN;
               end else begin
                  resp_now    = 1'b1;
                  resp_status = ST_RANGE;
               end
            end
            OP_LOCATE: begin
               launch.valid  = 1'b1;
               launch.locate = 1'b1;
               del_in        = 1'b0;
               state_in      = S_SCAN;
            end
            OP_INSERT: begin
               resp_now = 1'b1;
               if (!range_ins) begin
                  resp_status = ST_RANGE;
               end else if (full) begin
                  resp_status = ST_FULL;
               end else begin
                  cmd.ins  = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_DELETE: begin
               if (range_rd) begin
                  // read the victim first, shift down when the probe returns
                  launch.valid = 1'b1;
                  del_in       = 1'b1;
                  pos_in       = pos_w;
                  state_in     = S_SCAN;
               end else begin
                  resp_now    = 1'b1;
                  resp_status = ST_RANGE;
               end
            end
            OP_CLEAR: begin
               resp_now = 1'b1;
               count_in = '0;
            end
            default: begin
               resp_now = 1'b1;
            end
         endcase
      end

      if (resp_now) begin
         rsp_valid_in = 1'b1;
         status_in    = resp_status;
         rdval_in     = '0;
         fpos_in      = '0;
      end

      if ((state_ff == S_SCAN) && probe_ret.valid) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         rdval_in     = '0;
         fpos_in      = '0;
         if (del_ff) begin
            cmd.del  = 1'b1;
            cmd_pos  = pos_ff;
            count_in = count_ff - CW'(1);
            rdval_in = ret_value;
         end else if (probe_ret.locate) begin
            if (probe_ret.hit) begin
               fpos_in = POS_W'(probe_ret_pos);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end else begin
            rdval_in = ret_value;
         end
      end

      if (resp_now || ((state_ff == S_SCAN) && probe_ret.valid)) begin
         len_in   = POS_W'(count_in);
         empty_in = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      del_ff    <= del_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
      fpos_ff   <= fpos_in;
      len_ff    <= len_in;
      empty_ff  <= empty_in;
   end

   assign list_count              = cnt_w;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.read_value     = rdval_ff;
   assign rsp_chan.found_position = fpos_ff;
   assign rsp_chan.list_length    = len_ff;
   assign rsp_chan.is_empty       = empty_ff;

   `PAL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY), "length above capacity")
   `PAL_ASSERT_NOW(a_ret_in_scan, probe_ret.valid, state_ff == S_SCAN, "probe returned while idle")
   `PAL_ASSERT_NEXT(a_launch_scan, launch.valid, state_ff == S_SCAN, "probe launched without scan")
   `PAL_ASSERT_NOW(a_hold_in_scan, state_ff == S_SCAN, !req_chan.ready, "request taken during scan")

endmodule

// File: rtl/positional_array_list_unit.sv
// Insert, clear, unused codes and range/full errors answer in the cycle after the request beat,
// so with the response side ready they run at one beat per cycle.
// Get, locate and delete send a probe down the row of CAPACITY cells, one cell per cycle,
// and answer once the probe leaves the last cell; delete shifts the row as the probe returns.
// A new beat is taken only with no probe out and the response register free or leaving.
// Synchronous reset empties the list and drops any probe; entries are not cleared.
module positional_array_list_unit #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   pal_req_if.sink   req_chan,
   pal_rsp_if.source rsp_chan
);
   import pal_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   pal_cmd_type           cmd;
   logic [PW-1:0]         cmd_pos;
   logic [ELEM_WIDTH-1:0] cmd_word;
   logic [PW-1:0]         list_count;

   // index 0 and CAPACITY+1 are the zero ends of the row
   logic [ELEM_WIDTH-1:0] entry_pad [0:CAPACITY+1];

   pal_probe_type         probe_flags  [0:CAPACITY];
   logic [ELEM_WIDTH-1:0] probe_word   [0:CAPACITY];
   logic [PW-1:0]         probe_target [0:CAPACITY];
   logic [PW-1:0]         probe_pos    [0:CAPACITY];

   assign entry_pad[0]          = '0;
   assign entry_pad[CAPACITY+1] = '0;
   assign probe_pos[0]          = '0;

   pal_ctrl #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH),
      .PW         (PW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .cmd            (cmd),
      .cmd_pos        (cmd_pos),
      .cmd_word       (cmd_word),
      .list_count     (list_count),
      .launch         (probe_flags[0]),
      .launch_word    (probe_word[0]),
      .launch_target  (probe_target[0]),
      .probe_ret      (probe_flags[CAPACITY]),
      .probe_ret_word (probe_word[CAPACITY]),
      .probe_ret_pos  (probe_pos[CAPACITY])
   );

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         pal_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .PW         (PW),
            .POSITION   (g + 1)
         ) u_cell (
            .clock            (clock),
            .reset            (reset),
            .cmd              (cmd),
            .cmd_pos          (cmd_pos),
            .cmd_word         (cmd_word),
            .lower_word       (entry_pad[g]),
            .upper_word       (entry_pad[g+2]),
            .entry_word       (entry_pad[g+1]),
            .list_count       (list_count),
            .probe_in         (probe_flags[g]),
            .probe_word_in    (probe_word[g]),
            .probe_target_in  (probe_target[g]),
            .probe_pos_in     (probe_pos[g]),
            .probe_out        (probe_flags[g+1]),
            .probe_word_out   (probe_word[g+1]),
            .probe_target_out (probe_target[g+1]),
            .probe_pos_out    (probe_pos[g+1])
         );
      end
   endgenerate

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for positional_array_list_unit: ordered-list ops, range/full errors, stalls.
// Depends on pal_pkg and the pal_req_if / pal_rsp_if channel interfaces.
module tb;
   import pal_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int ELEM_WIDTH  = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   // codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_value;
      logic [POS_W-1:0]  found_position;
      logic [POS_W-1:0]  list_length;
      logic              is_empty;
   } list_result_type;

   logic clock = 1'b0;
   logic reset;

   pal_req_if req_if ();
   pal_rsp_if rsp_if ();

   positional_array_list_unit #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [DATA_W-1:0] shadow_entries [CAPACITY];
   int                shadow_len = 0;
   list_result_type   pending_results [$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct;
   int                recv_stall_pct;
   logic              hold_rsp = 1'b0;

   always #4 clock = ~clock;

   // Apply one operation to the shadow list and return the response it should produce.
   function automatic list_result_type apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                     logic [DATA_W-1:0] val);
      list_result_type r;
      int p;
      int i;
      p = pos;
      r.status         = ST_OK;
      r.read_value     = '0;
      r.found_position = '0;
      case (op)
         OP_GET: begin
            if (p < 1 || p > shadow_len) r.status = ST_RANGE;
            else r.read_value = shadow_entries[p-1];
         end
         OP_LOCATE: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < shadow_len; i++) begin
               if (r.status == ST_NOT_FOUND && shadow_entries[i] == val) begin
                  r.status         = ST_OK;
                  r.found_position = POS_W'(i + 1);
               end
            end
         end
         OP_INSERT: begin
            // range check wins over full
            if (p < 1 || p > shadow_len + 1) r.status = ST_RANGE;
            else if (shadow_len >= CAPACITY) r.status = ST_FULL;
            else begin
               for (i = shadow_len; i >= p; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p-1] = val;
               shadow_len++;
            end
         end
         OP_DELETE: begin
            if (p < 1 || p > shadow_len) r.status = ST_RANGE;
            else begin
               r.read_value = shadow_entries[p-1];
               for (i = p; i < shadow_len; i++) shadow_entries[i-1] = shadow_entries[i];
               shadow_len--;
            end
         end
         OP_CLEAR: shadow_len = 0;
         default: ;
      endcase
      r.list_length = POS_W'(shadow_len);
      r.is_empty    = (shadow_len == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   // Predict on each request beat, check each response beat against the oldest prediction.
   always @(posedge clock) begin : monitor
      list_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            pending_results.push_back(apply_list_op(req_if.operation, req_if.position,
                                                    req_if.value));
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_if.status, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch("status", rsp_if.status, want.status);
               if (rsp_if.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_if.read_value, want.read_value);
               if (rsp_if.found_position !== want.found_position)
                  report_mismatch("found_position", rsp_if.found_position, want.found_position);
               if (rsp_if.list_length !== want.list_length)
                  report_mismatch("list_length", rsp_if.list_length, want.list_length);
               if (rsp_if.is_empty !== want.is_empty)
                  report_mismatch("is_empty", rsp_if.is_empty, want.is_empty);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("positional_array_list_unit regression: fail");
         $finish;
      end
   end

   // Send one beat; returns at the accepting edge with valid still high.
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.position  <= pos;
      req_if.value     <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and hold until every predicted response is back.
   task automatic wait_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(7);
         2: return $urandom_range(1) ? '1 : '0;
         default: begin
            if (shadow_len > 0) return shadow_entries[$urandom_range(shadow_len - 1)];
            return $urandom;
         end
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(int span);
      if (span >= 1 && $urandom_range(99) < 88) return POS_W'($urandom_range(span, 1));
      return POS_W'($urandom_range(65));
   endfunction

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_beat(OP_GET, 1, '0);
      send_beat(OP_DELETE, 1, '0);
      send_beat(OP_LOCATE, 0, '0);
      send_beat(OP_INSERT, 0, 32'h1111_1111);
      send_beat(OP_INSERT, 2, 32'h2222_2222);
      send_beat(OP_INSERT, 1, 32'h0000_0000);
      send_beat(OP_INSERT, 2, 32'hFFFF_FFFF);
      send_beat(OP_INSERT, 1, 32'hA5A5_5A5A);
      send_beat(OP_INSERT, 4, 32'h8000_0001);
      send_beat(OP_INSERT, 3, 32'hFFFF_FFFF);
      send_beat(OP_GET, 1, '0);
      send_beat(OP_GET, 5, '1);
      send_beat(OP_GET, 6, '0);
      send_beat(OP_GET, 0, '0);
      // duplicate entries: first match wins
      send_beat(OP_LOCATE, 7'd65, 32'hFFFF_FFFF);
      send_beat(OP_LOCATE, 1, 32'h1234_5678);
      send_beat(OP_DELETE, 2, '0);
      send_beat(OP_DELETE, 7'd65, '0);
      send_beat(OP_GET, 7'd64, '0);
      send_beat(OP_INSERT, 7'd65, 32'h5555_5555);
      send_beat(OP_RSVD5, 2, '1);
      send_beat(OP_RSVD6, 0, '0);
      send_beat(OP_RSVD7, 7'd65, 32'h8000_0001);
      send_beat(OP_CLEAR, 7'd65, '1);
      // stale entries after clear must stay invisible
      send_beat(OP_GET, 1, '0);
      send_beat(OP_LOCATE, 1, 32'hA5A5_5A5A);
      wait_results();
   endtask

   task automatic test_fill_full();
      int k;
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      send_beat(OP_CLEAR, 0, '0);
      for (k = 0; k < CAPACITY; k++)
         send_beat(OP_INSERT, POS_W'($urandom_range(k + 1, 1)), pick_value());
      send_beat(OP_INSERT, 7'd65, 32'h0BAD_F00D);
      send_beat(OP_INSERT, 1, 32'h0BAD_F00D);
      send_beat(OP_INSERT, 0, 32'h0BAD_F00D);
      send_beat(OP_GET, 7'd64, '0);
      send_beat(OP_GET, 7'd65, '0);
      send_beat(OP_LOCATE, 0, shadow_entries[CAPACITY-1]);
      send_beat(OP_DELETE, 7'd64, '0);
      send_beat(OP_DELETE, 1, '0);
      send_beat(OP_INSERT, 7'd63, '1);
      wait_results();
   endtask

   // Hold the response side while the sender keeps offering, so the request side backs up.
   task automatic test_backpressure();
      int k;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (k = 0; k < 12; k++) begin
         if (k % 3 == 0) send_beat(OP_GET, pick_position(shadow_len), '0);
         else send_beat(OP_INSERT, pick_position(shadow_len + 1), pick_value());
      end
      wait_results();
   endtask

   task automatic test_random(input int n_items, input int idle_pct, input int stall_pct,
                              input int insert_pct);
      int k;
      int d;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (k = 0; k < n_items; k++) begin
         d = $urandom_range(99);
         if ($urandom_range(99) < insert_pct)
            send_beat(OP_INSERT, pick_position(shadow_len + 1), pick_value());
         else if (d < 38) send_beat(OP_DELETE, pick_position(shadow_len), pick_value());
         else if (d < 60) send_beat(OP_GET, pick_position(shadow_len), pick_value());
         else if (d < 90) send_beat(OP_LOCATE, POS_W'($urandom_range(65)), pick_value());
         else if (d < 95) send_beat(OP_CLEAR, POS_W'($urandom_range(65)), pick_value());
         else send_beat(OP_W'($urandom_range(OP_RSVD7, OP_RSVD5)), POS_W'($urandom_range(65)),
                        pick_value());
      end
      wait_results();
   endtask

   initial begin
      reset            = 1'b1;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      req_if.valid     = 1'b0;
      req_if.operation = OP_GET;
      req_if.position  = '0;
      req_if.value     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_full();
      test_backpressure();
      test_random(120, 0, 0, 45);
      test_random(120, 86, 0, 55);
      test_random(120, 0, 86, 45);
      test_random(100, 16, 16, 60);

      wait_results();
      repeat (CAPACITY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("positional_array_list_unit regression: pass");
      end else begin
         $display("positional_array_list_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: positional_array_list_unit.f
+incdir+rtl
rtl/pal_pkg.sv
rtl/pal_ifs.sv
rtl/pal_cell.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_unit.sv
tb/tb.sv
